/* rtl/atwe_pkg.sv */
// Package: shared constants, types and CORDIC angle table for the tilt estimator.
package atwe_pkg;

  localparam int unsigned WindowDef     = 180;
  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned AngleBitsDef  = 16;

  // Port field widths fixed by the interface.
  localparam int unsigned InBits  = 16;
  localparam int unsigned OutBits = 16;

  // CORDIC: 30 iterations, angle accumulator with pi = 2^31.
  localparam int unsigned CordicSteps = 30;
  localparam int unsigned StepBits    = 5;
  localparam int unsigned AccBits     = 34;
  // Vector datapath width: operands up to ~2^33 scaled by 2^16, with CORDIC gain.
  localparam int unsigned VecBits     = 54;
  localparam int unsigned SqBits      = 66;
  localparam int unsigned RootBits    = 33;

  localparam logic signed [AccBits-1:0] QuarterTurn = 34'sd1073741824;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_ROLL,
    ST_ROOT,
    ST_PITCH,
    ST_OUT
  } state_e;

  // Start commands from control to the CORDIC and root units.
  typedef struct packed {
    logic start_atan;
    logic start_root;
  } unit_cmd_t;

  function automatic logic [AccBits-1:0] atan_unit(input logic [StepBits-1:0] i);
    logic [AccBits-1:0] r;
    begin
      case (i)
        5'd0:  r = 34'd536870912;
        5'd1:  r = 34'd316933406;
        5'd2:  r = 34'd167458907;
        5'd3:  r = 34'd85004756;
        5'd4:  r = 34'd42667331;
        5'd5:  r = 34'd21354465;
        5'd6:  r = 34'd10679838;
        5'd7:  r = 34'd5340245;
        5'd8:  r = 34'd2670163;
        5'd9:  r = 34'd1335087;
        5'd10: r = 34'd667544;
        5'd11: r = 34'd333772;
        5'd12: r = 34'd166886;
        5'd13: r = 34'd83443;
        5'd14: r = 34'd41722;
        5'd15: r = 34'd20861;
        5'd16: r = 34'd10430;
        5'd17: r = 34'd5215;
        5'd18: r = 34'd2608;
        5'd19: r = 34'd1304;
        5'd20: r = 34'd652;
        5'd21: r = 34'd326;
        5'd22: r = 34'd163;
        5'd23: r = 34'd81;
        5'd24: r = 34'd41;
        5'd25: r = 34'd20;
        5'd26: r = 34'd10;
        5'd27: r = 34'd5;
        5'd28: r = 34'd3;
        5'd29: r = 34'd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

/* rtl/atwe_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module atwe_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 180
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/atwe_root.sv */
// Bit-serial integer square root: two radicand bits are brought in per cycle.
module atwe_root (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [atwe_pkg::SqBits-1:0]       rad_i,
  output logic                              done_o,
  output logic [atwe_pkg::RootBits-1:0]     root_o
);

  localparam int unsigned Steps  = atwe_pkg::SqBits / 2;
  localparam int unsigned CntW   = $clog2(Steps + 1);
  localparam int unsigned RemW   = atwe_pkg::RootBits + 3;

  logic [atwe_pkg::SqBits-1:0]   rad_q, rad_d;
  logic [RemW-1:0]               rem_q, rem_d;
  logic [atwe_pkg::RootBits-1:0] root_q, root_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic                          busy_q, busy_d, done_q, done_d;
  logic [RemW-1:0]               trial, shifted;

  // One restoring step: bring in two radicand bits, try subtract 4*root+1.
  always_comb begin
    shifted = {rem_q[RemW-3:0], rad_q[atwe_pkg::SqBits-1 -: 2]};
    trial   = shifted - {root_q, 2'b01};
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CntW'(Steps);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[atwe_pkg::SqBits-3:0], 2'b00};
      if (shifted >= {root_q, 2'b01}) begin
        rem_d  = trial;
        root_d = {root_q[atwe_pkg::RootBits-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        root_d = {root_q[atwe_pkg::RootBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* rtl/atwe_cordic.sv */
// Iterative vectoring CORDIC: atan2(num, den) as a rounded binary angle.
module atwe_cordic #(
  parameter int unsigned AngleBits = atwe_pkg::AngleBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [atwe_pkg::RootBits:0]  num_i,
  input  logic signed [atwe_pkg::RootBits:0]  den_i,
  output logic                                done_o,
  output logic [atwe_pkg::OutBits-1:0]        angle_o
);

  localparam int unsigned VB = atwe_pkg::VecBits;
  localparam int unsigned AB = atwe_pkg::AccBits;
  localparam int unsigned Sh = 32 - AngleBits;

  logic signed [VB-1:0] x_q, x_d, y_q, y_d, xs, ys, dx, dy;
  logic signed [AB-1:0] acc_q, acc_d, rnd;
  logic [atwe_pkg::StepBits-1:0] i_q, i_d;
  logic busy_q, busy_d, done_q, done_d, zero_q, zero_d;
  logic [AngleBits-1:0] ang;

  always_comb begin
    xs = VB'(den_i) <<< 16;
    ys = VB'(num_i) <<< 16;
    dx = y_q >>> i_q;
    dy = x_q >>> i_q;
    x_d = x_q; y_d = y_q; acc_d = acc_q; i_d = i_q;
    busy_d = busy_q; done_d = 1'b0; zero_d = zero_q;
    if (start_i) begin
      // Pre-rotate a left-half-plane vector by a quarter turn.
      zero_d = (num_i == '0) && (den_i == '0);
      i_d    = '0;
      busy_d = 1'b1;
      if (xs < 0) begin
        if (ys >= 0) begin
          x_d = ys; y_d = -xs; acc_d = atwe_pkg::QuarterTurn;
        end else begin
          x_d = -ys; y_d = xs; acc_d = -atwe_pkg::QuarterTurn;
        end
      end else begin
        x_d = xs; y_d = ys; acc_d = '0;
      end
    end else if (busy_q) begin
      // Advance one micro-rotation toward the x axis.
      if (y_q >= 0) begin
        x_d = x_q + dx; y_d = y_q - dy; acc_d = acc_q + AB'(atwe_pkg::atan_unit(i_q));
      end else begin
        x_d = x_q - dx; y_d = y_q + dy; acc_d = acc_q - AB'(atwe_pkg::atan_unit(i_q));
      end
      i_d = i_q + 1'b1;
      if (i_q == atwe_pkg::StepBits'(atwe_pkg::CordicSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Round to the output angle step and wrap.
  always_comb begin
    rnd = (acc_q + (AB'(1) <<< (Sh - 1))) >>> Sh;
    ang = zero_q ? '0 : rnd[AngleBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      i_q    <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    acc_q  <= acc_d;
    zero_q <= zero_d;
  end

  assign done_o  = done_q;
  assign angle_o = atwe_pkg::OutBits'($signed(ang));

endmodule

/* rtl/accel_tilt_window_estimator.sv */
// Top level: sample ring memory, running sums, sequencer and tilt arithmetic.
// One sample beat is taken at a time. During the first WINDOW samples a beat
// only stores and sums and gives no result. After that each beat reads the
// oldest sample through the registered ring memory read port, updates the sums,
// runs a 30-step CORDIC for roll, a 33-step square root and a 30-step CORDIC for
// pitch. The result is held in an output register until taken.
module accel_tilt_window_estimator #(
  parameter int unsigned WINDOW      = atwe_pkg::WindowDef,
  parameter int unsigned SAMPLE_BITS = atwe_pkg::SampleBitsDef,
  parameter int unsigned ANGLE_BITS  = atwe_pkg::AngleBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [atwe_pkg::InBits-1:0]       accel_x_i,
  input  logic [atwe_pkg::InBits-1:0]       accel_y_i,
  input  logic [atwe_pkg::InBits-1:0]       accel_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [atwe_pkg::OutBits-1:0]      roll_angle_o,
  output logic [atwe_pkg::OutBits-1:0]      pitch_angle_o,
  output logic                              is_first_o
);

  localparam int unsigned SlotW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FillW = $clog2(WINDOW + 1);
  localparam int unsigned SumW  = SAMPLE_BITS + $clog2(WINDOW) + 1;
  localparam int unsigned RB    = atwe_pkg::RootBits;

  atwe_pkg::state_e state_q, state_d;
  atwe_pkg::unit_cmd_t cmd;

  logic [SlotW-1:0] slot_q, slot_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic signed [SumW-1:0] sx_q, sy_q, sz_q, sx_d, sy_d, sz_d;
  logic signed [SAMPLE_BITS-1:0] ax_q, ay_q, az_q, ox, oy, oz;
  logic [3*SAMPLE_BITS-1:0] rd_data;
  logic we;
  logic latched_q, latched_d;
  logic [atwe_pkg::OutBits-1:0] roll_q, pitch_q, init_roll_q, init_pitch_q, ang;
  logic out_valid_q, first_q;
  logic signed [RB:0] c_num, c_den;
  logic c_done, r_done;
  logic [RB-1:0] root;
  logic [SumW-1:0] ym, zm;
  logic [atwe_pkg::SqBits-1:0] rad;
  logic accept;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == atwe_pkg::ST_IDLE);
  assign {ox, oy, oz} = rd_data;

  atwe_ram #(.Width(3*SAMPLE_BITS), .Depth(WINDOW)) u_ring (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (slot_q),
    .wdata_i ({ax_q, ay_q, az_q}),
    .raddr_i (slot_q),
    .rdata_o (rd_data)
  );

  // Magnitude squared for pitch denominator.
  always_comb begin
    ym  = sy_q[SumW-1] ? SumW'(-sy_q) : SumW'(sy_q);
    zm  = sz_q[SumW-1] ? SumW'(-sz_q) : SumW'(sz_q);
    rad = atwe_pkg::SqBits'(ym) * atwe_pkg::SqBits'(ym)
        + atwe_pkg::SqBits'(zm) * atwe_pkg::SqBits'(zm);
  end

  atwe_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd.start_root),
    .rad_i   (rad),
    .done_o  (r_done),
    .root_o  (root)
  );

  // Select CORDIC operands per phase.
  always_comb begin
    if (state_q == atwe_pkg::ST_UPDATE) begin
      c_num = (RB+1)'(sy_d);
      c_den = (RB+1)'(sz_d);
    end else begin
      c_num = -(RB+1)'(sx_q);
      c_den = {1'b0, root};
    end
  end

  atwe_cordic #(.AngleBits(ANGLE_BITS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd.start_atan),
    .num_i   (c_num),
    .den_i   (c_den),
    .done_o  (c_done),
    .angle_o (ang)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      atwe_pkg::ST_IDLE:   if (accept) state_d = atwe_pkg::ST_READ;
      atwe_pkg::ST_READ:   state_d = atwe_pkg::ST_UPDATE;
      atwe_pkg::ST_UPDATE: state_d = (fill_q < FillW'(WINDOW)) ? atwe_pkg::ST_IDLE
                                                             : atwe_pkg::ST_ROLL;
      atwe_pkg::ST_ROLL:   if (c_done) state_d = atwe_pkg::ST_ROOT;
      atwe_pkg::ST_ROOT:   if (r_done) state_d = atwe_pkg::ST_PITCH;
      atwe_pkg::ST_PITCH:  if (c_done) state_d = atwe_pkg::ST_OUT;
      atwe_pkg::ST_OUT:    if (!out_valid_q || out_ready_i) state_d = atwe_pkg::ST_IDLE;
      default:             state_d = atwe_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: sums, ring write, unit starts.
  always_comb begin
    we = 1'b0;
    cmd = '0;
    slot_d = slot_q; fill_d = fill_q;
    sx_d = sx_q; sy_d = sy_q; sz_d = sz_q;
    if (state_q == atwe_pkg::ST_UPDATE) begin
      we = 1'b1;
      sx_d = sx_q + SumW'(ax_q);
      sy_d = sy_q + SumW'(ay_q);
      sz_d = sz_q + SumW'(az_q);
      if (fill_q < FillW'(WINDOW)) begin
        fill_d = fill_q + 1'b1;
      end else begin
        sx_d = sx_d - SumW'(ox);
        sy_d = sy_d - SumW'(oy);
        sz_d = sz_d - SumW'(oz);
        cmd.start_atan = 1'b1;
      end
      slot_d = (slot_q == SlotW'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
    end
    if (state_q == atwe_pkg::ST_ROLL && c_done) cmd.start_root = 1'b1;
    if (state_q == atwe_pkg::ST_ROOT && r_done) cmd.start_atan = 1'b1;
  end

  assign latched_d = latched_q || (state_q == atwe_pkg::ST_OUT && state_d == atwe_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= atwe_pkg::ST_IDLE;
      slot_q       <= '0;
      fill_q       <= '0;
      sx_q         <= '0;
      sy_q         <= '0;
      sz_q         <= '0;
      latched_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      init_roll_q  <= '0;
      init_pitch_q <= '0;
    end else begin
      state_q   <= state_d;
      slot_q    <= slot_d;
      fill_q    <= fill_d;
      sx_q      <= sx_d;
      sy_q      <= sy_d;
      sz_q      <= sz_d;
      latched_q <= latched_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      // Load the output register and latch the initial pose on the first result.
      if (state_q == atwe_pkg::ST_OUT && state_d == atwe_pkg::ST_IDLE) begin
        out_valid_q <= 1'b1;
        if (!latched_q) begin
          init_roll_q  <= roll_q;
          init_pitch_q <= pitch_q;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ax_q <= accel_x_i[SAMPLE_BITS-1:0];
      ay_q <= accel_y_i[SAMPLE_BITS-1:0];
      az_q <= accel_z_i[SAMPLE_BITS-1:0];
    end
    if (state_q == atwe_pkg::ST_ROLL && c_done) roll_q <= ang;
    if (state_q == atwe_pkg::ST_PITCH && c_done) pitch_q <= ang;
    if (state_q == atwe_pkg::ST_OUT && state_d == atwe_pkg::ST_IDLE) begin
      roll_angle_o  <= roll_q;
      pitch_angle_o <= pitch_q;
      first_q       <= !latched_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_first_o  = first_q;

endmodule

/* bench/accel_tilt_window_estimator_tb.sv */
// Testbench: checks the windowed tilt estimator against an in-bench CORDIC predictor.
module accel_tilt_window_estimator_tb;

  localparam int unsigned Window     = atwe_pkg::WindowDef;
  localparam int unsigned NumRandom  = 1200;
  localparam int unsigned TailCycles = 300;
  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned HoldCycles = 3000;
  localparam longint      HalfTurn   = 64'sd2147483648;

  typedef struct {
    logic [atwe_pkg::OutBits-1:0] roll;
    logic [atwe_pkg::OutBits-1:0] pitch;
    logic                         first;
  } tilt_t;

  typedef struct {
    logic signed [atwe_pkg::InBits-1:0] x;
    logic signed [atwe_pkg::InBits-1:0] y;
    logic signed [atwe_pkg::InBits-1:0] z;
    int                                 rep;
    bit                                 typed;
    tilt_t                              want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [atwe_pkg::InBits-1:0] accel_x_i = '0;
  logic [atwe_pkg::InBits-1:0] accel_y_i = '0;
  logic [atwe_pkg::InBits-1:0] accel_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [atwe_pkg::OutBits-1:0] roll_angle_o;
  logic [atwe_pkg::OutBits-1:0] pitch_angle_o;
  logic is_first_o;

  accel_tilt_window_estimator u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .accel_x_i, .accel_y_i, .accel_z_i,
    .out_valid_o, .out_ready_i, .roll_angle_o, .pitch_angle_o, .is_first_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state
  logic signed [atwe_pkg::InBits-1:0] ring_x [Window];
  logic signed [atwe_pkg::InBits-1:0] ring_y [Window];
  logic signed [atwe_pkg::InBits-1:0] ring_z [Window];
  int unsigned slot_q, filled_q;
  longint sx, sy, sz;
  bit pose_seen;

  tilt_t tilt_q[$];
  int errors = 0;
  int results_seen = 0;
  int beats_sent = 0;
  int unsigned cycles = 0;
  bit no_idle = 1'b0;

  const longint atan_tab [atwe_pkg::CordicSteps] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC; pi = 2^31 internally, rounded to a 16-bit binary angle
  function automatic logic [atwe_pkg::OutBits-1:0] bam_atan2(longint num, longint den);
    longint x, y, acc, t, dx, dy;
    x = den * 65536;
    y = num * 65536;
    acc = 0;
    if (num == 0 && den == 0) return '0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; acc = HalfTurn / 2;
      end else begin
        x = -y; y = t; acc = -(HalfTurn / 2);
      end
    end
    for (int i = 0; i < atwe_pkg::CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; acc += atan_tab[i];
      end else begin
        x -= dx; y += dy; acc -= atan_tab[i];
      end
    end
    acc = (acc + 32768) >>> 16;
    return acc[atwe_pkg::OutBits-1:0];
  endfunction

  // Advance the window by one beat; returns 1 when a tilt result follows
  function automatic bit tilt_step(input logic signed [atwe_pkg::InBits-1:0] ax, ay, az,
                                   output tilt_t r);
    longint ym, zm;
    r = '{16'h0, 16'h0, 1'b0};
    // Fill phase: store and sum, no result
    if (filled_q < Window) begin
      sx += ax; sy += ay; sz += az;
      ring_x[slot_q] = ax; ring_y[slot_q] = ay; ring_z[slot_q] = az;
      filled_q++;
      slot_q = (slot_q + 1) % Window;
      return 1'b0;
    end
    // Replace the oldest sample
    sx -= ring_x[slot_q]; sy -= ring_y[slot_q]; sz -= ring_z[slot_q];
    sx += ax; sy += ay; sz += az;
    ring_x[slot_q] = ax; ring_y[slot_q] = ay; ring_z[slot_q] = az;
    slot_q = (slot_q + 1) % Window;
    ym = sy < 0 ? -sy : sy;
    zm = sz < 0 ? -sz : sz;
    r.roll = bam_atan2(sy, sz);
    r.pitch = bam_atan2(-sx, longint'(isqrt(ym * ym + zm * zm)));
    r.first = !pose_seen;
    pose_seen = 1'b1;
    return 1'b1;
  endfunction

  // Present one beat and hold it until taken; gap is the idle count after it
  task automatic send_beat(input logic signed [atwe_pkg::InBits-1:0] ax, ay, az,
                           input bit typed, input tilt_t want);
    tilt_t r;
    int gap;
    in_valid_i <= 1'b1;
    accel_x_i <= ax;
    accel_y_i <= ay;
    accel_z_i <= az;
    do @(posedge clk_i); while (!in_ready_o);
    if (tilt_step(ax, ay, az, r)) tilt_q.insert(tilt_q.size(), typed ? want : r);
    beats_sent++;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [atwe_pkg::InBits-1:0] draw_sample(int mode);
    case (mode)
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return $signed(16'($urandom_range(0, 64))) - 16'sd32;
      default: return 16'($urandom);
    endcase
  endfunction

  stim_row_t rows [10] = '{
    '{16'sd0, 16'sd0, 16'sd0, Window, 1'b0, '{16'h0, 16'h0, 1'b0}},
    // all-zero window: atan2 of zeros gives zero, first result marked
    '{16'sd0, 16'sd0, 16'sd0, 1, 1'b1, '{16'h0, 16'h0, 1'b1}},
    // zero y with negative z: roll is pi, wrapped to the most negative code
    '{16'sd0, 16'sd0, 16'sh8000, 1, 1'b1, '{16'h8000, 16'h0, 1'b0}},
    '{16'sd32767, 16'sd0, 16'sd0, 1, 1'b0, '{16'h0, 16'h0, 1'b0}},
    '{16'sh8000, 16'sd32767, 16'sd0, 1, 1'b0, '{16'h0, 16'h0, 1'b0}},
    '{16'sd0, 16'sh8000, 16'sd32767, 1, 1'b0, '{16'h0, 16'h0, 1'b0}},
    '{16'sh8000, 16'sh8000, 16'sh8000, 3, 1'b0, '{16'h0, 16'h0, 1'b0}},
    '{16'sd32767, 16'sd32767, 16'sd32767, 3, 1'b0, '{16'h0, 16'h0, 1'b0}},
    '{-16'sd1, 16'sd1, -16'sd1, 2, 1'b0, '{16'h0, 16'h0, 1'b0}},
    '{16'sh5555, -16'sh2aab, 16'sh2aaa, 2, 1'b0, '{16'h0, 16'h0, 1'b0}}
  };

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off, compare each result
  initial begin : result_side
    int stall;
    bit held;
    tilt_t w;
    held = 1'b0;
    @(posedge rst_ni);
    stall = $urandom_range(0, 15);
    forever begin
      if (!held && results_seen == 40) begin
        held = 1'b1;
        stall = HoldCycles;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      results_seen++;
      if (tilt_q.size() == 0) begin
        $display("%0t unexpected result roll=%h pitch=%h first=%b", $time,
                 roll_angle_o, pitch_angle_o, is_first_o);
        errors++;
      end else begin
        w = tilt_q[0];
        tilt_q.delete(0);
        if (roll_angle_o !== w.roll) begin
          $display("%0t roll exp=%h got=%h", $time, w.roll, roll_angle_o);
          errors++;
        end
        if (pitch_angle_o !== w.pitch) begin
          $display("%0t pitch exp=%h got=%h", $time, w.pitch, pitch_angle_o);
          errors++;
        end
        if (is_first_o !== w.first) begin
          $display("%0t is_first exp=%b got=%b", $time, w.first, is_first_o);
          errors++;
        end
      end
      stall = no_idle ? 0 : $urandom_range(0, 15);
    end
  end

  // Sample side: directed table, then random windows
  initial begin : sample_side
    int mode;
    tilt_t none;
    none = '{16'h0, 16'h0, 1'b0};
    slot_q = 0; filled_q = 0; sx = 0; sy = 0; sz = 0; pose_seen = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i])
      for (int k = 0; k < rows[i].rep; k++)
        send_beat(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].want);
    for (int n = 0; n < NumRandom; n++) begin
      no_idle = (n >= 600 && n < 750);
      // drain fully once, then go on
      if (n == 1000) begin
        in_valid_i <= 1'b0;
        while (tilt_q.size() != 0) @(posedge clk_i);
        repeat (TailCycles) @(posedge clk_i);
      end
      mode = $urandom_range(0, 9);
      mode = mode == 0 ? 0 : (mode < 3 ? 1 : 2);
      send_beat(draw_sample(mode), draw_sample(mode), draw_sample(mode), 1'b0, none);
    end
    no_idle = 1'b0;
    in_valid_i <= 1'b0;
    while (tilt_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    $display("Sent %0d sample beats (fill, extremes, pi wrap, random windows);", beats_sent);
    $display("checked %0d tilt results under random stalls and a long hold-off.", results_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
